// ----- src/quadrature_majority_filter_defines.svh -----
// Assertion macros shared by the RTL of the quadrature majority filter.
// Needs no other file; the using module must have i_clk and i_rst_n.
`ifndef QUADRATURE_MAJORITY_FILTER_DEFINES_SVH
`define QUADRATURE_MAJORITY_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QMF_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QMF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/qmf_pkg.sv -----
// Types and constants of the quadrature majority filter.
// No dependencies; used by qmf_window and the top level.
package qmf_pkg;

    localparam int WS_W = 5;          // width of the window size register
    localparam int CMP_W = 7;         // wide enough to compare against store depths up to 127
    localparam int RUN_W = 8;

    localparam logic [WS_W-1:0]  WINDOW_RESET = 5'd5;
    localparam logic [RUN_W-1:0] RUN_LIMIT    = 8'd255;
    localparam logic [RUN_W-1:0] STABLE_MIN   = 8'd2;

    // Control from the sequencer to each window slice.
    typedef struct packed {
        logic clear;   // empty the window and its count
        logic start;   // zero the count for a new word
        logic shift;   // rotate the window by one entry
        logic load;    // the entry passing the tap takes the new sample
        logic count;   // the entry passing the tap is inside the window
    } t_win_ctl;

endpackage

// ----- src/quadrature_majority_filter.sv -----
// Channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------
// input    | i_in_valid / o_in_ready    | i_cmd, i_a_sample, i_b_sample
// output   | o_out_valid / i_out_ready  | o_filtered_a, o_filtered_b, o_stable
// config   | i_cfg_we (no wait)         | i_cfg_data
//
// A sample word goes from ST_IDLE through ST_SCAN to ST_DONE, which registers its result once
// the output register is free; the windows rotate past a single tap one entry per cycle.
// A clear word goes straight to ST_DONE; one word is in work at a time, taken in ST_IDLE.
// Reset (synchronous, active low) and every configuration write empty the windows.
// A result waiting in the output register does not block acceptance of the next word.
// Top level of the quadrature majority filter; depends on qmf_pkg, qmf_window and
// quadrature_majority_filter_defines.svh.
`include "quadrature_majority_filter_defines.svh"

module quadrature_majority_filter
    import qmf_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [WS_W-1:0] i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_cmd,
    input  logic            i_a_sample,
    input  logic            i_b_sample,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_filtered_a,
    output logic            o_filtered_b,
    output logic            o_stable
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_wp, n_wp;
    logic [RUN_W-1:0] r_run, n_run;
    logic             r_held_a, n_held_a;
    logic             r_held_b, n_held_b;
    logic [WS_W-1:0]  r_ws;
    logic             r_cmd, r_a, r_b;
    logic             r_out_valid, n_out_valid;
    logic             r_fa, r_fb, r_st;

    logic [CW-1:0]    n_eff, wp_eff, wp_inc, ones_a, ones_b;
    logic             accept, done_fire, lvl_a, lvl_b;
    t_win_ctl         ctl;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign done_fire = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // Effective window size: zero counts as one, anything past the store depth saturates.
    always_comb begin
        if (r_ws == '0) begin
            n_eff = CW'(1);
        end else if ({{(CMP_W-WS_W){1'b0}}, r_ws} > CMP_W'(MAX_DEPTH)) begin
            n_eff = CW'(MAX_DEPTH);
        end else begin
            n_eff = CW'(r_ws);
        end
    end

    assign wp_eff = (r_wp >= n_eff) ? '0 : r_wp;
    assign wp_inc = wp_eff + CW'(1);

    always_comb begin
        ctl.clear = !i_rst_n || i_cfg_we || (done_fire && r_cmd);
        ctl.start = accept;
        ctl.shift = (r_state == ST_SCAN);
        ctl.load  = (r_state == ST_SCAN) && (r_idx == wp_eff);
        ctl.count = (r_idx < n_eff);
    end

    qmf_window #(
        .DEPTH (MAX_DEPTH),
        .CW    (CW)
    ) u_win_a (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_sample (r_a),
        .o_ones   (ones_a)
    );

    qmf_window #(
        .DEPTH (MAX_DEPTH),
        .CW    (CW)
    ) u_win_b (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_sample (r_b),
        .o_ones   (ones_b)
    );

    assign lvl_a = (ones_a > (n_eff >> 1));
    assign lvl_b = (ones_b > (n_eff >> 1));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_wp        = r_wp;
        n_run       = r_run;
        n_held_a    = r_held_a;
        n_held_b    = r_held_b;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_state = i_cmd ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_DONE: begin
                if (done_fire) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_cmd) begin
                        n_wp     = '0;
                        n_run    = '0;
                        n_held_a = 1'b0;
                        n_held_b = 1'b0;
                    end else begin
                        n_wp = (wp_inc == n_eff) ? '0 : wp_inc;
                        if (lvl_a == r_held_a && lvl_b == r_held_b) begin
                            if (r_run != RUN_LIMIT) begin
                                n_run = r_run + RUN_W'(1);
                            end
                        end else begin
                            n_run    = '0;
                            n_held_a = lvl_a;
                            n_held_b = lvl_b;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // The user must write the configuration only while idle (not enforced here); it restarts the filter.
        if (i_cfg_we) begin
            n_wp     = '0;
            n_run    = '0;
            n_held_a = 1'b0;
            n_held_b = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_wp        <= '0;
            r_run       <= '0;
            r_held_a    <= 1'b0;
            r_held_b    <= 1'b0;
            r_ws        <= WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_wp        <= n_wp;
            r_run       <= n_run;
            r_held_a    <= n_held_a;
            r_held_b    <= n_held_b;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_ws <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_a   <= i_a_sample;
            r_b   <= i_b_sample;
        end
        if (done_fire) begin
            r_fa <= n_held_a;
            r_fb <= n_held_b;
            r_st <= (n_run >= STABLE_MIN);
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_filtered_a = r_fa;
    assign o_filtered_b = r_fb;
    assign o_stable     = r_st;

    `QMF_CHECK_NOW(a_wp_in_window, r_state == ST_IDLE, r_wp < n_eff, "write position outside window")
    `QMF_CHECK_NOW(a_ones_bounded, r_state == ST_DONE, (ones_a <= n_eff) && (ones_b <= n_eff), "ones count exceeds window size")
    `QMF_CHECK_NEXT(a_clear_result, done_fire && r_cmd, o_out_valid && !o_filtered_a && !o_filtered_b && !o_stable, "clear word did not give a zero result")

endmodule

// ----- src/qmf_window.sv -----
// One circular sample window held as a rotating shift register, with a serial ones counter.
// Depends on qmf_pkg.
module qmf_window
    import qmf_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic          i_clk,
    input  t_win_ctl      i_ctl,
    input  logic          i_sample,
    output logic [CW-1:0] o_ones
);

    logic [DEPTH-1:0] r_win, n_win;
    logic [CW-1:0]    r_ones, n_ones;
    logic             tap;

    // Entry 0 is the tap; after DEPTH shifts the window is back in place.
    assign tap = i_ctl.load ? i_sample : r_win[0];

    always_comb begin
        n_win  = r_win;
        n_ones = r_ones;
        priority if (i_ctl.clear) begin
            n_win  = '0;
            n_ones = '0;
        end else if (i_ctl.start) begin
            n_ones = '0;
        end else if (i_ctl.shift) begin
            n_win = DEPTH'({tap, r_win} >> 1);
            if (i_ctl.count) begin
                n_ones = r_ones + CW'(tap);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_ones <= n_ones;
    end

    assign o_ones = r_ones;

endmodule
